[rtl/quad_x_motor_mixer_assert.svh]
// Assertion macros used by the checker file.
// Both expect clk and arst_n in scope.
`ifndef QUAD_X_MOTOR_MIXER_ASSERT_SVH
`define QUAD_X_MOTOR_MIXER_ASSERT_SVH

// same-cycle implication
`define QXM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quad_x_motor_mixer: assertion failed");

// next-cycle implication
`define QXM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quad_x_motor_mixer: assertion failed");

`endif

[rtl/qxm_pkg.sv]
`timescale 1ns / 1ps
package qxm_pkg;

	localparam int DUTY_FRAC_BITS = 16;
	localparam int DUTY_W         = 17;
	localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(1) << DUTY_FRAC_BITS;

	// duty accumulator, LSB 2^-36
	localparam int D_W       = 58;
	localparam int RND_SHIFT = 36 - DUTY_FRAC_BITS;
	localparam logic [D_W-1:0] RND_HALF = D_W'(1) << (RND_SHIFT - 1);

	localparam int SQ_IN_W  = 44;
	localparam int SQ_OUT_W = 22;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [1:0] {
		CMD_MIX    = 2'd0,
		CMD_ARM    = 2'd1,
		CMD_DISARM = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RP_GAIN  = 3'd0,
		REG_YAW_GAIN = 3'd1,
		REG_QUAD     = 3'd2,
		REG_LIN      = 3'd3,
		REG_OFFSET   = 3'd4
	} reg_idx_t;

	localparam logic [23:0] RP_GAIN_RST  = 24'd712348;
	localparam logic [23:0] YAW_GAIN_RST = 24'd1687335;
	localparam logic [23:0] QUAD_RST     = 24'd95473;
	localparam logic [23:0] LIN_RST      = 24'd112119;
	localparam logic [15:0] OFFSET_RST   = 16'd271;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_Q,
		ST_MUL_Y,
		ST_CAP_Y,
		ST_SUM,
		ST_SQRT,
		ST_MUL_A,
		ST_MUL_B,
		ST_ACC,
		ST_WR
	} state_t;

	typedef struct packed {
		logic                start;
		logic [SQ_IN_W-1:0]  radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic                done;
		logic [SQ_OUT_W-1:0] root;
	} sqrt_rsp_t;

endpackage

[rtl/qxm_req_if.sv]
`timescale 1ns / 1ps
interface qxm_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [23:0] total_thrust;
	logic signed [23:0] roll_torque;
	logic signed [23:0] pitch_torque;
	logic signed [23:0] yaw_torque;
	logic [31:0]        stamp_in;

	modport source (output valid, cmd, total_thrust, roll_torque, pitch_torque,
		yaw_torque, stamp_in, input ready);
	modport sink (input valid, cmd, total_thrust, roll_torque, pitch_torque,
		yaw_torque, stamp_in, output ready);
endinterface

[rtl/qxm_rsp_if.sv]
`timescale 1ns / 1ps
interface qxm_rsp_if;
	logic        valid;
	logic        ready;
	logic [16:0] duty_front_right;
	logic [16:0] duty_rear_right;
	logic [16:0] duty_rear_left;
	logic [16:0] duty_front_left;
	logic [31:0] stamp_out;
	logic        drive_enable;

	modport source (output valid, duty_front_right, duty_rear_right, duty_rear_left,
		duty_front_left, stamp_out, drive_enable, input ready);
	modport sink (input valid, duty_front_right, duty_rear_right, duty_rear_left,
		duty_front_left, stamp_out, drive_enable, output ready);
endinterface

[rtl/qxm_mul.sv]
`timescale 1ns / 1ps
module qxm_mul (
	input  logic                                clk,
	input  logic signed [qxm_pkg::MUL_W-1:0]    a,
	input  logic signed [qxm_pkg::MUL_W-1:0]    b,
	output logic signed [qxm_pkg::PROD_W-1:0]   prod_q
);
	import qxm_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end
endmodule

[rtl/qxm_sqrt.sv]
`timescale 1ns / 1ps
module qxm_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qxm_pkg::sqrt_req_t   req,
	output qxm_pkg::sqrt_rsp_t   rsp
);
	import qxm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [SQ_IN_W-1:0]   x_q;
	logic [SQ_IN_W-1:0]   res_q;
	logic [SQ_IN_W-1:0]   bit_q;
	logic [SQ_IN_W-1:0]   trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0];
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	// one result bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= req.radicand;
			res_q <= '0;
			bit_q <= SQ_IN_W'(1) << (SQ_IN_W - 2);
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = res_q[SQ_OUT_W-1:0];
endmodule

[rtl/quad_x_motor_mixer.sv]
`timescale 1ns / 1ps
// X-layout quadcopter mixer: an update item gives four rotor duties (full scale 65536)
// from collective thrust and roll, pitch and yaw torques, plus the stamp and the armed
// flag; arm gives no result, disarm while armed gives one all-zero result. One item is
// processed at a time and req.ready is high only while the block is idle. An update forms
// the roll, pitch and yaw products, then per rotor a square root and two more products
// when its thrust is positive and a zero duty otherwise, paced by the square-root unit
// that resolves one root bit per cycle and by a single shared 33x33 multiplier. A result
// that finds the previous one still waiting in the output register holds the block until
// that one is taken. A finished result waits in the output register while the next item
// is accepted.
module quad_x_motor_mixer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [qxm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qxm_pkg::CFG_DATA_W-1:0]    cfg_data,
	qxm_req_if.sink                           req,
	qxm_rsp_if.source                         rsp
);
	import qxm_pkg::*;

	logic [23:0] gr_q, gy_q, qa_q, lb_q;
	logic [15:0] oc_q;

	state_t state_q, state_d;
	logic [1:0] rot_q;
	logic armed_q;
	logic accept;
	logic wr_fire;

	logic signed [23:0] thr_q, rt_q, pt_q, yt_q;
	logic [31:0] stamp_q;
	logic en_q;
	logic signed [47:0] p_q, q_q, y_q;
	logic [31:0] t_q;
	logic [D_W-1:0] d_q;
	logic [DUTY_W-1:0] duty_q [4];

	logic out_valid_q;
	logic [DUTY_W-1:0] out_duty_q [4];
	logic [31:0] out_stamp_q;
	logic out_en_q;

	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;
	sqrt_req_t sq_req;
	sqrt_rsp_t sq_rsp;

	logic signed [51:0] ut, pe, qe, ye, s_val;
	logic s_pos;
	logic [D_W-1:0] d_sum, d_sh;
	logic [DUTY_W-1:0] duty_val;

	qxm_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	qxm_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gr_q <= RP_GAIN_RST;
			gy_q <= YAW_GAIN_RST;
			qa_q <= QUAD_RST;
			lb_q <= LIN_RST;
			oc_q <= OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RP_GAIN:  gr_q <= cfg_data;
				REG_YAW_GAIN: gy_q <= cfg_data;
				REG_QUAD:     qa_q <= cfg_data;
				REG_LIN:      lb_q <= cfg_data;
				REG_OFFSET:   oc_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign accept  = req.valid && req.ready;
	assign wr_fire = (state_q == ST_WR) && (!out_valid_q || rsp.ready);

	// rotor thrust at LSB 2^-40, signs per rotor position
	always_comb begin
		ut = {{10{thr_q[23]}}, thr_q, 18'b0};
		pe = {{4{p_q[47]}}, p_q};
		qe = {{4{q_q[47]}}, q_q};
		ye = {{4{y_q[47]}}, y_q};
		case (rot_q)
			2'd0:    s_val = ut - pe + qe + ye;
			2'd1:    s_val = ut - pe - qe - ye;
			2'd2:    s_val = ut + pe - qe + ye;
			default: s_val = ut + pe + qe - ye;
		endcase
		s_pos = !s_val[51] && (s_val != '0);
	end

	always_comb begin
		d_sum = d_q + D_W'({prod_q[45:0], 4'b0000}) + RND_HALF;
		d_sh  = d_sum >> RND_SHIFT;
		duty_val = (d_sh > D_W'(DUTY_FULL)) ? DUTY_FULL : d_sh[DUTY_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.cmd)
						CMD_MIX:    state_d = ST_MUL_P;
						CMD_DISARM: state_d = armed_q ? ST_WR : ST_IDLE;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL_P: state_d = ST_MUL_Q;
			ST_MUL_Q: state_d = ST_MUL_Y;
			ST_MUL_Y: state_d = ST_CAP_Y;
			ST_CAP_Y: state_d = ST_SUM;
			ST_SUM: begin
				if (s_pos) begin
					state_d = ST_SQRT;
				end else if (rot_q == 2'd3) begin
					state_d = ST_WR;
				end
			end
			ST_SQRT: begin
				if (sq_rsp.done) begin
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_ACC;
			ST_ACC:   state_d = (rot_q == 2'd3) ? ST_WR : ST_SUM;
			ST_WR: begin
				if (wr_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready       = 1'b0;
		mul_a           = '0;
		mul_b           = '0;
		sq_req.start    = 1'b0;
		sq_req.radicand = {s_val[51:20], 12'b0};
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_MUL_P: begin
				mul_a = {9'b0, gr_q};
				mul_b = {{9{rt_q[23]}}, rt_q};
			end
			ST_MUL_Q: begin
				mul_a = {9'b0, gr_q};
				mul_b = {{9{pt_q[23]}}, pt_q};
			end
			ST_MUL_Y: begin
				mul_a = {9'b0, gy_q};
				mul_b = {{9{yt_q[23]}}, yt_q};
			end
			ST_SUM: sq_req.start = s_pos;
			ST_MUL_A: begin
				mul_a = {9'b0, qa_q};
				mul_b = {1'b0, t_q};
			end
			ST_MUL_B: begin
				mul_a = {9'b0, lb_q};
				mul_b = {11'b0, sq_rsp.root};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rot_q       <= 2'd0;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rot_q <= 2'd0;
				if (req.cmd == CMD_ARM) begin
					armed_q <= 1'b1;
				end else if (req.cmd == CMD_DISARM) begin
					armed_q <= 1'b0;
				end
			end
			if ((state_q == ST_SUM && !s_pos) || state_q == ST_ACC) begin
				rot_q <= rot_q + 2'd1;
			end
			if (wr_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			thr_q   <= req.total_thrust;
			rt_q    <= req.roll_torque;
			pt_q    <= req.pitch_torque;
			yt_q    <= req.yaw_torque;
			stamp_q <= (req.cmd == CMD_MIX) ? req.stamp_in : 32'd0;
			en_q    <= (req.cmd == CMD_MIX) ? armed_q : 1'b0;
			// disarm result carries zero duties
			for (int i = 0; i < 4; i++) begin
				duty_q[i] <= '0;
			end
		end
		case (state_q)
			ST_MUL_Q: p_q <= prod_q[47:0];
			ST_MUL_Y: q_q <= prod_q[47:0];
			ST_CAP_Y: y_q <= prod_q[47:0];
			ST_SUM: begin
				if (s_pos) begin
					t_q <= s_val[51:20];
				end else begin
					duty_q[rot_q] <= '0;
				end
			end
			ST_MUL_B: d_q <= D_W'(prod_q[55:0]) + D_W'({oc_q, 20'b0});
			ST_ACC:   duty_q[rot_q] <= duty_val;
			default: ;
		endcase
		if (wr_fire) begin
			for (int i = 0; i < 4; i++) begin
				out_duty_q[i] <= duty_q[i];
			end
			out_stamp_q <= stamp_q;
			out_en_q    <= en_q;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.duty_front_right = out_duty_q[0];
	assign rsp.duty_rear_right  = out_duty_q[1];
	assign rsp.duty_rear_left   = out_duty_q[2];
	assign rsp.duty_front_left  = out_duty_q[3];
	assign rsp.stamp_out        = out_stamp_q;
	assign rsp.drive_enable     = out_en_q;
endmodule

[rtl/qxm_check.sv]
`timescale 1ns / 1ps
`include "quad_x_motor_mixer_assert.svh"
module qxm_check (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_cmd,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [16:0] duty_fr,
	input logic [16:0] duty_rr,
	input logic [16:0] duty_rl,
	input logic [16:0] duty_fl
);
	import qxm_pkg::*;

	logic duty_ok;

	assign duty_ok = (duty_fr <= DUTY_FULL) && (duty_rr <= DUTY_FULL) &&
		(duty_rl <= DUTY_FULL) && (duty_fl <= DUTY_FULL);

	// hold a stalled result
	`QXM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

	// an accepted update keeps the block busy
	`QXM_ASSERT_NEXT(a_busy_after_mix, req_valid && req_ready && req_cmd == CMD_MIX, !req_ready)

	// duties never pass full scale
	`QXM_ASSERT_NOW(a_duty_range, rsp_valid, duty_ok)
endmodule

bind quad_x_motor_mixer qxm_check u_qxm_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_cmd   (req.cmd),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.duty_fr   (rsp.duty_front_right),
	.duty_rr   (rsp.duty_rear_right),
	.duty_rl   (rsp.duty_rear_left),
	.duty_fl   (rsp.duty_front_left)
);
